>>> rtl/eqt_pkg.sv
`default_nettype none

package eqt_pkg;

	localparam int TABLE_BITS = 10;
	localparam int SHIFT = 16 - TABLE_BITS;
	localparam int QW = TABLE_BITS - 1;
	localparam int QN = (1 << (TABLE_BITS - 2)) + 1;
	localparam logic [TABLE_BITS-1:0] QUARTER = TABLE_BITS'(1 << (TABLE_BITS - 2));
	localparam logic [TABLE_BITS-1:0] RMASK = TABLE_BITS'((1 << (TABLE_BITS - 2)) - 1);
	localparam logic [63:0] Q60_PI = 64'h3243F6A8885A308D;
	localparam logic signed [16:0] ONE_POS = 17'sd16384;
	localparam logic signed [16:0] ONE_NEG = -17'sd16384;

	typedef logic signed [15:0] q14_t;
	typedef logic [TABLE_BITS-1:0] idx_t;
	typedef q14_t qtab_t [QN];

	typedef struct packed {
		q14_t s0;
		q14_t c0;
		q14_t s1;
		q14_t c1;
		q14_t s2;
		q14_t c2;
	} trig_t;

	typedef struct packed {
		q14_t s0;
		q14_t c0;
		q14_t s2;
		q14_t c2;
		q14_t s12;
		q14_t c12;
		q14_t c0s1;
		q14_t s0c1;
		q14_t c0c1;
		q14_t s0s1;
	} prod1_t;

	typedef struct packed {
		q14_t wa;
		q14_t wb;
		q14_t xa;
		q14_t xb;
		q14_t ya;
		q14_t yb;
		q14_t za;
		q14_t zb;
	} prod2_t;

	function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		p = {64'b0, a} * {64'b0, b};
		return p[123:60];
	endfunction

	function automatic logic [63:0] div_term(input logic [63:0] t, input logic [3:0] k);
		logic [63:0] d;
		unique case (k)
			4'd1: d = t / 64'd6;
			4'd2: d = t / 64'd20;
			4'd3: d = t / 64'd42;
			4'd4: d = t / 64'd72;
			4'd5: d = t / 64'd110;
			4'd6: d = t / 64'd156;
			4'd7: d = t / 64'd210;
			4'd8: d = t / 64'd272;
			4'd9: d = t / 64'd342;
			4'd10: d = t / 64'd420;
			4'd11: d = t / 64'd506;
			4'd12: d = t / 64'd600;
			4'd13: d = t / 64'd702;
			default: d = t;
		endcase
		return d;
	endfunction

	// first-quadrant sine by taylor series in q4.60
	function automatic q14_t quad_sine(input logic [15:0] r);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] rnd;
		x = 64'(r) * (Q60_PI >> 15);
		x2 = mul_q60(x, x);
		term = x;
		sum = x;
		for (int k = 1; k <= 13; k++) begin
			term = div_term(mul_q60(term, x2), 4'(k));
			if (k % 2 == 1) begin
				sum = sum - term;
			end else begin
				sum = sum + term;
			end
		end
		rnd = sum + (64'd1 << 45);
		return q14_t'(rnd >> 46);
	endfunction

	function automatic qtab_t gen_qtab();
		qtab_t t;
		for (int j = 0; j < QN; j++) begin
			t[j] = quad_sine(16'(j << SHIFT));
		end
		return t;
	endfunction

	localparam qtab_t QTAB = gen_qtab();

	// full-circle sine from the quarter-wave table
	function automatic q14_t sin_lookup(input idx_t idx);
		logic [1:0] q;
		logic [QW-1:0] r;
		q14_t v;
		q = idx[TABLE_BITS-1 -: 2];
		r = QW'(idx & RMASK);
		if (q[0]) begin
			v = QTAB[QW'(QN - 1) - r];
		end else begin
			v = QTAB[r];
		end
		return q[1] ? -v : v;
	endfunction

	// halve toward zero, keep the top bits as table index
	function automatic idx_t half_index(input logic signed [15:0] a);
		logic signed [15:0] h;
		h = (a + $signed({15'b0, a[15]})) >>> 1;
		return h[15 -: TABLE_BITS];
	endfunction

	// q2.14 product, round half up
	function automatic q14_t mul_rnd(input q14_t a, input q14_t b);
		logic signed [31:0] p;
		p = 32'(a) * 32'(b) + 32'sd8192;
		return q14_t'(p >>> 14);
	endfunction

	function automatic q14_t sat_q(input logic signed [16:0] v);
		q14_t r;
		if (v > ONE_POS) begin
			r = q14_t'(ONE_POS);
		end else if (v < ONE_NEG) begin
			r = q14_t'(ONE_NEG);
		end else begin
			r = q14_t'(v);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

>>> rtl/euler_to_quaternion_table.sv
// channel   signals                               direction
// request   in_valid, in_ready, angle_a/b/c       in
// result    out_valid, out_ready, quat_w/x/y/z    out
//
// four register stages: table lookup, inner products, outer products, sums
// one request per cycle unless stalled; results pass each stage register in turn
// each stage has its own valid bit and moves when the next one is free or empty
// arst_n clears only the valid bits; a stalled result holds in the output register
`default_nettype none

module euler_to_quaternion_table
	import eqt_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic signed [15:0] angle_a,
	input  wire logic signed [15:0] angle_b,
	input  wire logic signed [15:0] angle_c,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [15:0]      quat_w,
	output logic signed [15:0]      quat_x,
	output logic signed [15:0]      quat_y,
	output logic signed [15:0]      quat_z
);

	logic   lk_valid;
	logic   lk_ready;
	trig_t  trig;
	logic   pr_valid;
	logic   pr_ready;
	prod2_t prod;

	eqt_lookup u_lookup (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (in_valid),
		.up_ready (in_ready),
		.angle_a  (angle_a),
		.angle_b  (angle_b),
		.angle_c  (angle_c),
		.dn_valid (lk_valid),
		.dn_ready (lk_ready),
		.trig     (trig)
	);

	eqt_products u_products (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (lk_valid),
		.up_ready (lk_ready),
		.trig     (trig),
		.dn_valid (pr_valid),
		.dn_ready (pr_ready),
		.prod     (prod)
	);

	eqt_sum u_sum (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (pr_valid),
		.up_ready (pr_ready),
		.prod     (prod),
		.dn_valid (out_valid),
		.dn_ready (out_ready),
		.quat_w   (quat_w),
		.quat_x   (quat_x),
		.quat_y   (quat_y),
		.quat_z   (quat_z)
	);

	a_w_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (quat_w <= 16'sd16384 && quat_w >= -16'sd16384))
		else $error("quat_w out of range");

	a_xyz_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (quat_x <= 16'sd16384 && quat_x >= -16'sd16384
			&& quat_y <= 16'sd16384 && quat_y >= -16'sd16384
			&& quat_z <= 16'sd16384 && quat_z >= -16'sd16384))
		else $error("vector part out of range");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(!lk_valid && !pr_valid && !out_valid) |-> in_ready)
		else $error("empty pipeline refuses request");

	a_lookup_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(lk_valid && !lk_ready) |=> lk_valid)
		else $error("lookup stage dropped a stalled request");

endmodule

`default_nettype wire

>>> rtl/eqt_lookup.sv
`default_nettype none

module eqt_lookup
	import eqt_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               up_valid,
	output logic                    up_ready,
	input  wire logic signed [15:0] angle_a,
	input  wire logic signed [15:0] angle_b,
	input  wire logic signed [15:0] angle_c,
	output logic                    dn_valid,
	input  wire logic               dn_ready,
	output trig_t                   trig
);

	logic  valid_s1;
	trig_t trig_s1;
	idx_t  ia;
	idx_t  ib;
	idx_t  ic;

	assign up_ready = !valid_s1 || dn_ready;
	assign dn_valid = valid_s1;
	assign trig     = trig_s1;

	assign ia = half_index(angle_a);
	assign ib = half_index(angle_b);
	assign ic = half_index(angle_c);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (up_ready) begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && up_ready) begin
			trig_s1.s0 <= sin_lookup(ia);
			trig_s1.c0 <= sin_lookup(ia + QUARTER);
			trig_s1.s1 <= sin_lookup(ib);
			trig_s1.c1 <= sin_lookup(ib + QUARTER);
			trig_s1.s2 <= sin_lookup(ic);
			trig_s1.c2 <= sin_lookup(ic + QUARTER);
		end
	end

endmodule

`default_nettype wire

>>> rtl/eqt_products.sv
`default_nettype none

module eqt_products
	import eqt_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  up_valid,
	output logic       up_ready,
	input  wire trig_t trig,
	output logic       dn_valid,
	input  wire logic  dn_ready,
	output prod2_t     prod
);

	logic   valid_s2;
	logic   valid_s3;
	logic   ready_s3;
	prod1_t p_s2;
	prod2_t p_s3;

	assign ready_s3 = !valid_s3 || dn_ready;
	assign up_ready = !valid_s2 || ready_s3;
	assign dn_valid = valid_s3;
	assign prod     = p_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (up_ready) begin
				valid_s2 <= up_valid;
			end
			if (ready_s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	// inner products
	always_ff @(posedge clk) begin
		if (up_valid && up_ready) begin
			p_s2.s0   <= trig.s0;
			p_s2.c0   <= trig.c0;
			p_s2.s2   <= trig.s2;
			p_s2.c2   <= trig.c2;
			p_s2.s12  <= mul_rnd(trig.s1, trig.s2);
			p_s2.c12  <= mul_rnd(trig.c1, trig.c2);
			p_s2.c0s1 <= mul_rnd(trig.c0, trig.s1);
			p_s2.s0c1 <= mul_rnd(trig.s0, trig.c1);
			p_s2.c0c1 <= mul_rnd(trig.c0, trig.c1);
			p_s2.s0s1 <= mul_rnd(trig.s0, trig.s1);
		end
	end

	// outer products
	always_ff @(posedge clk) begin
		if (valid_s2 && ready_s3) begin
			p_s3.wa <= mul_rnd(p_s2.c0, p_s2.c12);
			p_s3.wb <= mul_rnd(p_s2.s0, p_s2.s12);
			p_s3.xa <= mul_rnd(p_s2.s0, p_s2.c12);
			p_s3.xb <= mul_rnd(p_s2.c0, p_s2.s12);
			p_s3.ya <= mul_rnd(p_s2.c2, p_s2.c0s1);
			p_s3.yb <= mul_rnd(p_s2.s2, p_s2.s0c1);
			p_s3.za <= mul_rnd(p_s2.s2, p_s2.c0c1);
			p_s3.zb <= mul_rnd(p_s2.c2, p_s2.s0s1);
		end
	end

endmodule

`default_nettype wire

>>> rtl/eqt_sum.sv
`default_nettype none

module eqt_sum
	import eqt_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   up_valid,
	output logic        up_ready,
	input  wire prod2_t prod,
	output logic        dn_valid,
	input  wire logic   dn_ready,
	output q14_t        quat_w,
	output q14_t        quat_x,
	output q14_t        quat_y,
	output q14_t        quat_z
);

	logic valid_s4;
	q14_t w_s4;
	q14_t x_s4;
	q14_t y_s4;
	q14_t z_s4;

	assign up_ready = !valid_s4 || dn_ready;
	assign dn_valid = valid_s4;
	assign quat_w   = w_s4;
	assign quat_x   = x_s4;
	assign quat_y   = y_s4;
	assign quat_z   = z_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (up_ready) begin
			valid_s4 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && up_ready) begin
			w_s4 <= sat_q(17'(prod.wa) + 17'(prod.wb));
			x_s4 <= sat_q(17'(prod.xa) - 17'(prod.xb));
			y_s4 <= sat_q(17'(prod.ya) + 17'(prod.yb));
			z_s4 <= sat_q(17'(prod.za) - 17'(prod.zb));
		end
	end

endmodule

`default_nettype wire
